>>> src/assert_macros.svh
// Assertion macros used by the framer sequencer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge outside reset.
`define HRSC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checks that an expression never holds outside reset.
`define HRSC_NEVER(lbl, expr, msg) \
  `HRSC_ASSERT(lbl, !(expr), msg)

`endif

>>> src/hrsc_pkg.sv
// Package with the types and constants of the report size class framer.
`timescale 1ns / 1ps
package hrsc_pkg;

  localparam int unsigned NumRegs = 4;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned MaxMessageBytes = 65535;
  localparam logic [7:0] FixedClassSize = 8'd254;
  localparam logic [7:0] ClassResetTable [8] = '{
    8'd13, 8'd29, 8'd61, 8'd125, 8'd254, 8'd254, 8'd254, 8'd254
  };

  typedef enum logic [1:0] {
    KIND_ID   = 2'd0,
    KIND_LEN  = 2'd1,
    KIND_DATA = 2'd2,
    KIND_PAD  = 2'd3
  } kind_e;

  typedef struct packed {
    logic [7:0] id;
    logic [7:0] len;
    logic [7:0] pad;
  } class_sel_t;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] value;
    logic [7:0] pad_count;
    logic       end_of_report;
    logic       last_of_run;
  } result_t;

endpackage

>>> src/hrsc_if.sv
// Request channel interfaces for message bytes in and report results out.
`timescale 1ns / 1ps
interface hrsc_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  data_byte;
  logic [15:0] bytes_remaining;

  modport source (output valid, data_byte, bytes_remaining, input ready);
  modport sink (input valid, data_byte, bytes_remaining, output ready);
endinterface

interface hrsc_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] value;
  logic [7:0] pad_count;
  logic       end_of_report;
  logic       last_of_run;

  modport source (output valid, kind, value, pad_count, end_of_report, last_of_run,
                  input ready);
  modport sink (input valid, kind, value, pad_count, end_of_report, last_of_run,
                output ready);
endinterface

>>> src/hrsc_cfg_regs.sv
// Size class registers with their write port.
`timescale 1ns / 1ps
module hrsc_cfg_regs #(
  parameter int unsigned NumClasses = 4
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [hrsc_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [7:0]                      cfg_data_i,
  output logic [NumClasses-1:0][7:0]      sizes_o
);
  import hrsc_pkg::*;

  for (genvar i = 0; i < NumClasses; i++) begin : g_class
    if (i < NumRegs) begin : g_reg
      logic [7:0] size_q;

      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          size_q <= ClassResetTable[i];
        end else if (cfg_we_i && (cfg_idx_i == CfgIdxW'(i))) begin
          size_q <= cfg_data_i;
        end
      end

      // A size of zero still carries one byte per report.
      assign sizes_o[i] = (size_q == 8'd0) ? 8'd1 : size_q;
    end else begin : g_fixed
      assign sizes_o[i] = FixedClassSize;
    end
  end

endmodule

>>> src/hrsc_class_sel.sv
// Picks the report class and chunk length for the bytes still to send.
`timescale 1ns / 1ps
module hrsc_class_sel #(
  parameter int unsigned NumClasses = 4
) (
  input  logic [15:0]                   rem_i,
  input  logic [NumClasses-1:0][7:0]    sizes_i,
  output hrsc_pkg::class_sel_t          sel_o
);
  import hrsc_pkg::*;

  localparam int unsigned ClsW = (NumClasses > 1) ? $clog2(NumClasses) : 1;
  localparam logic [15:0] MaxRem =
      (MaxMessageBytes >= 65535) ? 16'hFFFF : 16'(MaxMessageBytes);

  logic [15:0]     rem_eff;
  logic [ClsW-1:0] cls;
  logic [7:0]      size;
  logic [7:0]      len;

  always_comb begin
    rem_eff = (rem_i == 16'd0) ? 16'd1 : rem_i;
    if (rem_eff > MaxRem) begin
      rem_eff = MaxRem;
    end
    cls = ClsW'(NumClasses - 1);
    for (int i = NumClasses - 1; i >= 0; i--) begin
      if ({8'd0, sizes_i[i]} >= rem_eff) begin
        cls = ClsW'(i);
      end
    end
    size = sizes_i[cls];
    len = (rem_eff > {8'd0, size}) ? size : rem_eff[7:0];
    sel_o.id  = 8'(cls) + 8'd1;
    sel_o.len = len;
    sel_o.pad = size - len;
  end

endmodule

>>> src/hrsc_seq.sv
// Holds one message byte and steps through the results that it causes.
`timescale 1ns / 1ps
module hrsc_seq (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  hrsc_in_if.sink                in_i,
  output logic [15:0]            rem_o,
  input  hrsc_pkg::class_sel_t   sel_i,
  output logic                   res_valid_o,
  output hrsc_pkg::result_t      res_o,
  input  logic                   res_ready_i
);
  import hrsc_pkg::*;
  `include "assert_macros.svh"

  logic        item_v_q, item_v_d;
  logic [7:0]  data_q;
  logic [15:0] rem_q;
  logic [1:0]  step_q, step_d;
  logic [7:0]  chunk_left_q, chunk_left_d;
  logic [7:0]  pad_q, pad_d;

  logic        start;
  logic [7:0]  left_now;
  logic [7:0]  pad_now;
  logic [7:0]  left_after;
  kind_e       kind;
  kind_e       last_kind;
  logic        is_last;
  logic        load;
  logic        done;
  logic        accept;

  always_comb begin
    start      = (chunk_left_q == 8'd0);
    left_now   = start ? sel_i.len : chunk_left_q;
    pad_now    = start ? sel_i.pad : pad_q;
    left_after = left_now - 8'd1;
    kind       = kind_e'(start ? step_q : step_q + 2'd2);
    last_kind  = (left_after == 8'd0) ? KIND_PAD : KIND_DATA;
    is_last    = (kind == last_kind);

    load   = item_v_q && res_ready_i;
    done   = load && is_last;
    in_i.ready = !item_v_q || done;
    accept = in_i.valid && in_i.ready;

    item_v_d = accept ? 1'b1 : (done ? 1'b0 : item_v_q);
    step_d   = done ? 2'd0 : (load ? step_q + 2'd1 : step_q);

    chunk_left_d = chunk_left_q;
    pad_d        = pad_q;
    if (done) begin
      chunk_left_d = left_after;
      pad_d        = (left_after == 8'd0) ? 8'd0 : pad_now;
    end

    res_o.kind          = kind;
    res_o.value         = 8'd0;
    res_o.pad_count     = 8'd0;
    res_o.end_of_report = (kind == KIND_PAD);
    res_o.last_of_run   = is_last;
    unique case (kind)
      KIND_ID:   res_o.value = sel_i.id;
      KIND_LEN:  res_o.value = sel_i.len;
      KIND_DATA: res_o.value = data_q;
      KIND_PAD:  res_o.pad_count = pad_now;
      default:   res_o.value = 8'd0;
    endcase
  end

  assign res_valid_o = item_v_q;
  assign rem_o       = rem_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_v_q     <= 1'b0;
      step_q       <= 2'd0;
      chunk_left_q <= 8'd0;
      pad_q        <= 8'd0;
    end else begin
      item_v_q     <= item_v_d;
      step_q       <= step_d;
      chunk_left_q <= chunk_left_d;
      pad_q        <= pad_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      data_q <= in_i.data_byte;
      rem_q  <= in_i.bytes_remaining;
    end
  end

  `HRSC_ASSERT(a_pad_clear_between_chunks, (chunk_left_q == 8'd0) |-> (pad_q == 8'd0), "padding count left over outside a chunk")
  `HRSC_ASSERT(a_pad_closes_chunk, (load && (kind == KIND_PAD)) |=> (chunk_left_q == 8'd0), "chunk still open after its padding run")
  `HRSC_NEVER(a_no_header_mid_chunk, item_v_q && !start && (step_q > 2'd1), "header step inside an open chunk")

endmodule

>>> src/hrsc_out_reg.sv
// Result register between the sequencer and the output channel.
`timescale 1ns / 1ps
module hrsc_out_reg (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                res_valid_i,
  input  hrsc_pkg::result_t   res_i,
  output logic                res_ready_o,
  hrsc_out_if.source          out_o
);
  import hrsc_pkg::*;

  logic    valid_q, valid_d;
  result_t res_q;

  always_comb begin
    res_ready_o = !valid_q || out_o.ready;
    valid_d     = res_ready_o ? res_valid_i : valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready_o && res_valid_i) begin
      res_q <= res_i;
    end
  end

  assign out_o.valid         = valid_q;
  assign out_o.kind          = res_q.kind;
  assign out_o.value         = res_q.value;
  assign out_o.pad_count     = res_q.pad_count;
  assign out_o.end_of_report = res_q.end_of_report;
  assign out_o.last_of_run   = res_q.last_of_run;

endmodule

>>> src/hid_report_size_class_framer.sv
// Top level of the report size class framer.
//
//   Channel  Direction  Carries
//   in_i     sink       data_byte, bytes_remaining
//   out_o    source     kind, value, pad_count, end_of_report, last_of_run
//   cfg      write      cfg_we_i, cfg_idx_i, cfg_data_i (size classes 0 to 3)
//
// One result leaves per cycle while the output is not stalled; a byte causes one
// to four results (report ID and length at a chunk start, data, padding run).
// The step counter in the sequencer steps through the results of the held byte.
// Reset clears the chunk state and loads the default class sizes.
// A stalled output holds its result register; the next byte is taken in the
// cycle that the held byte's final result moves into that register.
`timescale 1ns / 1ps
module hid_report_size_class_framer #(
  parameter int unsigned NUM_SIZE_CLASSES = 4
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  hrsc_in_if.sink                       in_i,
  hrsc_out_if.source                    out_o,
  input  logic                          cfg_we_i,
  input  logic [hrsc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [7:0]                    cfg_data_i
);
  import hrsc_pkg::*;

  logic [NUM_SIZE_CLASSES-1:0][7:0] sizes;
  logic [15:0]                      rem;
  class_sel_t                       sel;
  logic                             res_valid;
  logic                             res_ready;
  result_t                          res;

  hrsc_cfg_regs #(
    .NumClasses(NUM_SIZE_CLASSES)
  ) u_cfg_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .sizes_o    (sizes)
  );

  hrsc_class_sel #(
    .NumClasses(NUM_SIZE_CLASSES)
  ) u_class_sel (
    .rem_i   (rem),
    .sizes_i (sizes),
    .sel_o   (sel)
  );

  hrsc_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .rem_o       (rem),
    .sel_i       (sel),
    .res_valid_o (res_valid),
    .res_o       (res),
    .res_ready_i (res_ready)
  );

  hrsc_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_i       (res),
    .res_ready_o (res_ready),
    .out_o       (out_o)
  );

endmodule
